// ===== design/ffd_pkg.sv =====
// shared types and constants of the fall detector
`timescale 1ns / 1ps
`default_nettype none
package ffd_pkg;

  // configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 34;
  localparam int LVL_W      = 34;
  localparam int MS_W       = 16;
  localparam int GAIN_W     = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FF_LEVEL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMP_LEVEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FF_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd4;

  // register reset values
  localparam logic [LVL_W-1:0]  RST_FF_LEVEL  = 34'd16777216;
  localparam logic [LVL_W-1:0]  RST_IMP_LEVEL = 34'd419430400;
  localparam logic [MS_W-1:0]   RST_FF_MIN    = 16'd100;
  localparam logic [MS_W-1:0]   RST_WINDOW    = 16'd2000;
  localparam logic [GAIN_W-1:0] RST_GAIN      = 16'd1311;

  // detector phase codes
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_FREE   = 2'd1;
  localparam logic [1:0] PH_WAIT   = 2'd2;
  localparam logic [1:0] PH_UNUSED = 2'd3;

  // pipeline control from the top level to lanes and merge stage
  typedef struct packed {
    logic acc;  // input word taken this cycle
    logic adv;  // pipeline moves this cycle
    logic upd;  // merge stage loads a word into the output register
  } ffd_ctl_t;

endpackage
`default_nettype wire

// ===== design/ffd_if.sv =====
// valid/ready channel interfaces for samples and results
`timescale 1ns / 1ps
`default_nettype none
interface ffd_in_if #(
  parameter int SAMPLE_BITS = 16,
  parameter int TIME_BITS   = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] accel_x;
  logic signed [SAMPLE_BITS-1:0] accel_y;
  logic signed [SAMPLE_BITS-1:0] accel_z;
  logic        [TIME_BITS-1:0]   now_ms;

  modport source (output valid, accel_x, accel_y, accel_z, now_ms, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, now_ms, output ready);
endinterface

interface ffd_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_BITS:0] dyn_x;
  logic signed [SAMPLE_BITS:0] dyn_y;
  logic signed [SAMPLE_BITS:0] dyn_z;
  logic                        fall_flag;
  logic [1:0]                  phase;

  modport source (output valid, dyn_x, dyn_y, dyn_z, fall_flag, phase, input ready);
  modport sink   (input valid, dyn_x, dyn_y, dyn_z, fall_flag, phase, output ready);
endinterface
`default_nettype wire

// ===== design/ffd_lane.sv =====
// one axis lane: gravity low-pass, dynamic acceleration and its square
`timescale 1ns / 1ps
`default_nettype none
module ffd_lane #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire ffd_pkg::ffd_ctl_t                ctl,
  input  wire        [ffd_pkg::GAIN_W-1:0]      gain,
  input  wire signed [SAMPLE_BITS-1:0]          raw,
  output logic signed [SAMPLE_BITS+2:0]         dyn,
  output logic        [2*(SAMPLE_BITS+3)-1:0]   sq
);

  localparam int GW = SAMPLE_BITS + 18;          // gravity estimate, Q.16
  localparam int FW = GW + 1;                    // filter difference
  localparam int PW = FW + ffd_pkg::GAIN_W + 1;  // gain product
  localparam int IW = GW - 16;                   // integer part of gravity
  localparam int DW = SAMPLE_BITS + 3;           // dynamic value

  logic signed [GW-1:0] gravity_r;
  logic signed [GW-1:0] gravity_nxt;
  logic signed [FW-1:0] diff;
  logic signed [PW-1:0] prod;
  logic signed [SAMPLE_BITS-1:0] raw_r;
  logic signed [IW-1:0] gint_r;
  logic signed [DW-1:0] dyn_nxt;
  logic signed [2*DW-1:0] sq_nxt;

  // filter step, product floored by arithmetic shift
  always_comb begin
    diff = {{(FW-SAMPLE_BITS-16){raw[SAMPLE_BITS-1]}}, raw, 16'b0}
         - {gravity_r[GW-1], gravity_r};
    prod = {{(PW-FW){diff[FW-1]}}, diff} * $signed({{(PW-ffd_pkg::GAIN_W){1'b0}}, gain});
    gravity_nxt = gravity_r + prod[GW+15:16];
  end

  // gravity state advances with each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r <= '0;
    end else if (ctl.acc) begin
      gravity_r <= gravity_nxt;
    end
  end

  // stage 1: sample and integer part of updated gravity
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      raw_r  <= raw;
      gint_r <= gravity_nxt[GW-1:16];
    end
  end

  // stage 2: dynamic value and its square, signed DW by DW product
  always_comb begin
    dyn_nxt = {{(DW-SAMPLE_BITS){raw_r[SAMPLE_BITS-1]}}, raw_r}
            - {{(DW-IW){gint_r[IW-1]}}, gint_r};
    sq_nxt  = (2*DW)'(dyn_nxt) * (2*DW)'(dyn_nxt);
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      dyn <= dyn_nxt;
      sq  <= sq_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/ffd_merge.sv =====
// merge stage: magnitude sum, phase machine and output register
`timescale 1ns / 1ps
`default_nettype none
module ffd_merge #(
  parameter int SAMPLE_BITS = 16,
  parameter int TIME_BITS   = 32
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire ffd_pkg::ffd_ctl_t               ctl,
  input  wire        [ffd_pkg::LVL_W-1:0]      ff_level,
  input  wire        [ffd_pkg::LVL_W-1:0]      imp_level,
  input  wire        [ffd_pkg::MS_W-1:0]       ff_min_ms,
  input  wire        [ffd_pkg::MS_W-1:0]       window_ms,
  input  wire        [TIME_BITS-1:0]           now_ms,
  input  wire signed [SAMPLE_BITS+2:0]         dyn_x,
  input  wire signed [SAMPLE_BITS+2:0]         dyn_y,
  input  wire signed [SAMPLE_BITS+2:0]         dyn_z,
  input  wire        [2*(SAMPLE_BITS+3)-1:0]   sq_x,
  input  wire        [2*(SAMPLE_BITS+3)-1:0]   sq_y,
  input  wire        [2*(SAMPLE_BITS+3)-1:0]   sq_z,
  output logic signed [SAMPLE_BITS:0]          out_dyn_x,
  output logic signed [SAMPLE_BITS:0]          out_dyn_y,
  output logic signed [SAMPLE_BITS:0]          out_dyn_z,
  output logic                                 out_fall,
  output logic [1:0]                           out_phase
);

  localparam int SW = 2 * (SAMPLE_BITS + 3);
  localparam int MW = SW + 2;
  localparam int CW = (MW > ffd_pkg::LVL_W) ? MW : ffd_pkg::LVL_W;

  logic [1:0]           phase_r;
  logic [1:0]           phase_nxt;
  logic [TIME_BITS-1:0] start_r;
  logic [TIME_BITS-1:0] start_nxt;
  logic                 fall_nxt;
  logic [MW-1:0]        mag;
  logic [CW-1:0]        mag_c;
  logic [CW-1:0]        ff_c;
  logic [CW-1:0]        imp_c;
  logic [TIME_BITS-1:0] elapsed;
  logic [TIME_BITS-1:0] min_t;
  logic [TIME_BITS-1:0] win_t;

  // squared magnitude and elapsed time
  always_comb begin
    mag     = MW'(sq_x) + MW'(sq_y) + MW'(sq_z);
    mag_c   = CW'(mag);
    ff_c    = CW'(ff_level);
    imp_c   = CW'(imp_level);
    elapsed = now_ms - start_r;
    min_t   = TIME_BITS'(ff_min_ms);
    win_t   = TIME_BITS'(window_ms);
  end

  // idle / freefall / impact-wait machine, unused code acts as idle
  always_comb begin
    phase_nxt = phase_r;
    start_nxt = start_r;
    fall_nxt  = 1'b0;
    unique case (phase_r)
      ffd_pkg::PH_FREE: begin
        if (mag_c >= ff_c) begin
          if (elapsed >= min_t) begin
            phase_nxt = ffd_pkg::PH_WAIT;
            start_nxt = now_ms;
          end else begin
            phase_nxt = ffd_pkg::PH_IDLE;
          end
        end else if (elapsed > win_t) begin
          phase_nxt = ffd_pkg::PH_IDLE;
        end
      end
      ffd_pkg::PH_WAIT: begin
        if (mag_c > imp_c) begin
          phase_nxt = ffd_pkg::PH_IDLE;
          fall_nxt  = 1'b1;
        end else if (elapsed > win_t) begin
          phase_nxt = ffd_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_nxt = ffd_pkg::PH_IDLE;
        if (mag_c < ff_c) begin
          phase_nxt = ffd_pkg::PH_FREE;
          start_nxt = now_ms;
        end
      end
    endcase
  end

  // machine state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ffd_pkg::PH_IDLE;
      start_r <= '0;
    end else if (ctl.upd) begin
      phase_r <= phase_nxt;
      start_r <= start_nxt;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      out_dyn_x <= dyn_x[SAMPLE_BITS:0];
      out_dyn_y <= dyn_y[SAMPLE_BITS:0];
      out_dyn_z <= dyn_z[SAMPLE_BITS:0];
      out_fall  <= fall_nxt;
      out_phase <= phase_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/freefall_impact_fall_detector_top.sv =====
// top level of the freefall / impact fall detector
//
//   channel  dir  handshake          contents
//   in_ch    in   valid / ready      accel_x, accel_y, accel_z, now_ms
//   out_ch   out  valid / ready      dyn_x, dyn_y, dyn_z, fall_flag, phase
//   cfg_*    in   cfg_we             cfg_idx, cfg_data (five registers)
//
// one word per cycle unless the output stalls; each word passes the lane
// filter stage, lane square stage and merge stage into the output register.
// in each lane the gravity feedback is combinational around the gravity register.
// reset clears gravity estimates, phase, start time and registers to defaults.
// a stalled output holds the whole pipeline; in ready = out ready or empty output.
`timescale 1ns / 1ps
`default_nettype none
module freefall_impact_fall_detector_top #(
  parameter int SAMPLE_BITS = 16,
  parameter int TIME_BITS   = 32
) (
  input  wire                               clk,
  input  wire                               rst_n,
  ffd_in_if.sink                            in_ch,
  ffd_out_if.source                         out_ch,
  input  wire                               cfg_we,
  input  wire [ffd_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  wire [ffd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int DW = SAMPLE_BITS + 3;

  logic [ffd_pkg::LVL_W-1:0]  ff_level_r;
  logic [ffd_pkg::LVL_W-1:0]  imp_level_r;
  logic [ffd_pkg::MS_W-1:0]   ff_min_r;
  logic [ffd_pkg::MS_W-1:0]   window_r;
  logic [ffd_pkg::GAIN_W-1:0] gain_r;

  ffd_pkg::ffd_ctl_t    ctl;
  logic                 s1_valid_r;
  logic                 s2_valid_r;
  logic                 out_valid_r;
  logic [TIME_BITS-1:0] s1_now_r;
  logic [TIME_BITS-1:0] s2_now_r;

  logic signed [DW-1:0]   dyn_x;
  logic signed [DW-1:0]   dyn_y;
  logic signed [DW-1:0]   dyn_z;
  logic        [2*DW-1:0] sq_x;
  logic        [2*DW-1:0] sq_y;
  logic        [2*DW-1:0] sq_z;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff_level_r  <= ffd_pkg::RST_FF_LEVEL;
      imp_level_r <= ffd_pkg::RST_IMP_LEVEL;
      ff_min_r    <= ffd_pkg::RST_FF_MIN;
      window_r    <= ffd_pkg::RST_WINDOW;
      gain_r      <= ffd_pkg::RST_GAIN;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ffd_pkg::REG_FF_LEVEL:  ff_level_r  <= cfg_data[ffd_pkg::LVL_W-1:0];
        ffd_pkg::REG_IMP_LEVEL: imp_level_r <= cfg_data[ffd_pkg::LVL_W-1:0];
        ffd_pkg::REG_FF_MIN:    ff_min_r    <= cfg_data[ffd_pkg::MS_W-1:0];
        ffd_pkg::REG_WINDOW:    window_r    <= cfg_data[ffd_pkg::MS_W-1:0];
        ffd_pkg::REG_GAIN:      gain_r      <= cfg_data[ffd_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control: all stages move when the output register can load
  always_comb begin
    ctl.adv = !out_valid_r || out_ch.ready;
    ctl.acc = ctl.adv && in_ch.valid;
    ctl.upd = ctl.adv && s2_valid_r;
  end

  assign in_ch.ready  = ctl.adv;
  assign out_ch.valid = out_valid_r;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (ctl.adv) begin
      s1_valid_r  <= in_ch.valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  // timestamp travels alongside the lanes
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      s1_now_r <= in_ch.now_ms;
      s2_now_r <= s1_now_r;
    end
  end

  // one lane per axis
  ffd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .gain(gain_r),
    .raw(in_ch.accel_x), .dyn(dyn_x), .sq(sq_x)
  );

  ffd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .gain(gain_r),
    .raw(in_ch.accel_y), .dyn(dyn_y), .sq(sq_y)
  );

  ffd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_z (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .gain(gain_r),
    .raw(in_ch.accel_z), .dyn(dyn_z), .sq(sq_z)
  );

  // merge of the three lanes
  ffd_merge #(.SAMPLE_BITS(SAMPLE_BITS), .TIME_BITS(TIME_BITS)) u_merge (
    .clk(clk), .rst_n(rst_n), .ctl(ctl),
    .ff_level(ff_level_r), .imp_level(imp_level_r),
    .ff_min_ms(ff_min_r), .window_ms(window_r),
    .now_ms(s2_now_r),
    .dyn_x(dyn_x), .dyn_y(dyn_y), .dyn_z(dyn_z),
    .sq_x(sq_x), .sq_y(sq_y), .sq_z(sq_z),
    .out_dyn_x(out_ch.dyn_x), .out_dyn_y(out_ch.dyn_y), .out_dyn_z(out_ch.dyn_z),
    .out_fall(out_ch.fall_flag), .out_phase(out_ch.phase)
  );

endmodule
`default_nettype wire

// ===== design/ffd_checker.sv =====
// port-level checks of the fall detector and their binding
`timescale 1ns / 1ps
`default_nettype none
module ffd_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input wire                    clk,
  input wire                    rst_n,
  input wire                    in_ready,
  input wire                    out_valid,
  input wire                    out_ready,
  input wire [SAMPLE_BITS:0]    out_dyn_x,
  input wire                    out_fall,
  input wire [1:0]              out_phase
);

  // a held word keeps its dyn_x, fall flag and phase
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dyn_x) && $stable(out_phase)
      && $stable(out_fall))
    else $error("stalled output word changed");

  // the unused phase code never shows
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_phase != ffd_pkg::PH_UNUSED)
    else $error("output phase holds the unused code");

  // a confirmed fall leaves the machine idle
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fall |-> out_phase == ffd_pkg::PH_IDLE)
    else $error("fall flagged outside idle");

  // an empty output register never blocks the input
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind freefall_impact_fall_detector_top ffd_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_ffd_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_dyn_x(out_ch.dyn_x),
  .out_fall(out_ch.fall_flag),
  .out_phase(out_ch.phase)
);
`default_nettype wire
